// ===== src/rme_pkg.sv =====
`timescale 1ns / 1ps

package rme_pkg;

  localparam int DATA_W       = 32;
  localparam int WORD_W       = 16;
  localparam int OPC_W        = 4;
  localparam int IDX_W        = 6;
  localparam int COND_W       = 3;
  localparam int R1_LSB       = 4;
  localparam int R2_LSB       = 10;
  localparam int NUM_REGS_DEF = 64;

  typedef enum logic [OPC_W-1:0] {
    OP_ADD   = 4'd0,
    OP_SUB   = 4'd1,
    OP_MUL   = 4'd2,
    OP_DIV   = 4'd3,
    OP_CMP   = 4'd4,
    OP_COPY  = 4'd5,
    OP_JMP   = 4'd6,
    OP_LOAD  = 4'd7,
    OP_INPUT = 4'd8,
    OP_OUT   = 4'd9,
    OP_HALT  = 4'd10,
    OP_NOP   = 4'd15
  } op_t;

  typedef enum logic [COND_W-1:0] {
    COND_ALWAYS  = 3'd0,
    COND_ZERO    = 3'd1,
    COND_NZERO   = 3'd2,
    COND_POS     = 3'd3,
    COND_NEG     = 3'd4,
    COND_NOT_NEG = 3'd5,
    COND_NOT_POS = 3'd6,
    COND_NEVER   = 3'd7
  } cond_t;

  typedef enum logic [1:0] {
    FLAG_ZERO = 2'd0,
    FLAG_POS  = 2'd1,
    FLAG_NEG  = 2'd2
  } flag_t;

  typedef struct packed {
    op_t               op;
    cond_t             cond;
    logic [IDX_W-1:0]  r1;
    logic [IDX_W-1:0]  r2;
    logic [DATA_W-1:0] imm;
    logic [DATA_W-1:0] key;
  } instr_t;

  function automatic flag_t flag_of(input logic [DATA_W-1:0] v);
    flag_t f;
    if (v == '0) begin
      f = FLAG_ZERO;
    end else if (v[DATA_W-1]) begin
      f = FLAG_NEG;
    end else begin
      f = FLAG_POS;
    end
    return f;
  endfunction

  function automatic logic cond_met(input cond_t c, input flag_t f);
    logic m;
    unique case (c)
      COND_ALWAYS:  m = 1'b1;
      COND_ZERO:    m = (f == FLAG_ZERO);
      COND_NZERO:   m = (f != FLAG_ZERO);
      COND_POS:     m = (f == FLAG_POS);
      COND_NEG:     m = (f == FLAG_NEG);
      COND_NOT_NEG: m = (f != FLAG_NEG);
      COND_NOT_POS: m = (f != FLAG_POS);
      default:      m = 1'b0;
    endcase
    return m;
  endfunction

endpackage

// ===== src/register_machine_executor.sv =====
`timescale 1ns / 1ps

// Register machine executor: runs one instruction per input transaction and
// returns exactly one result transaction for it.
// Input channel (in_valid/in_ready): instruction word, immediate and keyboard
// value. A two-entry queue takes transactions while the execute side is busy.
// Output channel (out_valid/out_ready): next PC, display strobe and value,
// sign flag and halt bit, held in an output register.
// Each instruction is popped from the queue with its register-file read, then
// passes the execute and write-back states to the output register; a divide
// by a nonzero divisor runs the one-bit-per-cycle divider (32 steps plus sign
// fix-up), then the quotient and remainder register-file writes.
// One instruction executes at a time; the register file has one write port.
// Reset (rst_n low, synchronous) clears all registers to zero, the flag to
// zero, PC to 0 and the halt bit; the register file is usable at once.
// After a halt every later transaction yields the frozen PC and flag with
// halted set. If the receiver stalls, the result holds in the output register,
// execution stops at its next result and the queue then fills and drops
// in_ready.

module register_machine_executor #(
  parameter int NUM_REGS = rme_pkg::NUM_REGS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [rme_pkg::WORD_W-1:0] in_instr_word,
  input  logic signed [rme_pkg::DATA_W-1:0] in_immediate,
  input  logic signed [rme_pkg::DATA_W-1:0] in_keyboard_value,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [rme_pkg::DATA_W-1:0] out_next_pc,
  output logic                       out_display_valid,
  output logic signed [rme_pkg::DATA_W-1:0] out_display_value,
  output logic [1:0]                 out_sign_flag,
  output logic                       out_halted
);

  import rme_pkg::*;

  logic   q_valid;
  logic   q_pop;
  instr_t q_data;

  rme_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_instr_word    (in_instr_word),
    .in_immediate     (in_immediate),
    .in_keyboard_value(in_keyboard_value),
    .q_valid          (q_valid),
    .q_pop            (q_pop),
    .q_data           (q_data)
  );

  rme_back #(
    .NUM_REGS(NUM_REGS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .q_pop            (q_pop),
    .q_data           (q_data),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_next_pc      (out_next_pc),
    .out_display_valid(out_display_valid),
    .out_display_value(out_display_value),
    .out_sign_flag    (out_sign_flag),
    .out_halted       (out_halted)
  );

`ifndef SYNTHESIS
  a_pop_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("dequeue from empty queue");

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_display_not_halted: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_display_valid) |-> !out_halted)
    else $error("display strobe on a halted result");

  a_display_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_display_valid) |-> (out_display_value == '0))
    else $error("display value nonzero without strobe");
`endif

endmodule

// ===== src/rme_ram.sv =====
`timescale 1ns / 1ps

module rme_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

// ===== src/rme_div.sv =====
`timescale 1ns / 1ps

module rme_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [rme_pkg::DATA_W-1:0] dividend,
  input  logic [rme_pkg::DATA_W-1:0] divisor,
  output logic                      done,
  output logic [rme_pkg::DATA_W-1:0] quo,
  output logic [rme_pkg::DATA_W-1:0] rem
);

  import rme_pkg::*;

  localparam int CW = $clog2(DATA_W);

  logic          busy_r;
  logic          fix_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [DATA_W:0]   rem_r;
  logic [DATA_W-1:0] quo_r;
  logic [DATA_W-1:0] dvs_r;
  logic              qneg_r;
  logic              rneg_r;
  logic [DATA_W-1:0] quo_out_r;
  logic [DATA_W-1:0] rem_out_r;

  logic [DATA_W:0]   shifted;
  logic              ge;
  logic [DATA_W-1:0] dd_abs;
  logic [DATA_W-1:0] dv_abs;

  assign dd_abs  = dividend[DATA_W-1] ? (~dividend + 1'b1) : dividend;
  assign dv_abs  = divisor[DATA_W-1] ? (~divisor + 1'b1) : divisor;
  assign shifted = {rem_r[DATA_W-1:0], quo_r[DATA_W-1]};
  assign ge      = (shifted >= {1'b0, dvs_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fix_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= fix_r;
      fix_r  <= busy_r && !start && (cnt_r == CW'(DATA_W - 1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(DATA_W - 1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= '0;
      quo_r  <= dd_abs;
      dvs_r  <= dv_abs;
      qneg_r <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
      rneg_r <= dividend[DATA_W-1];
    end else if (busy_r) begin
      rem_r <= ge ? (shifted - {1'b0, dvs_r}) : shifted;
      quo_r <= {quo_r[DATA_W-2:0], ge};
    end
    if (fix_r) begin
      quo_out_r <= qneg_r ? (~quo_r + 1'b1) : quo_r;
      rem_out_r <= rneg_r ? (~rem_r[DATA_W-1:0] + 1'b1) : rem_r[DATA_W-1:0];
    end
  end

  assign done = done_r;
  assign quo  = quo_out_r;
  assign rem  = rem_out_r;

endmodule

// ===== src/rme_front.sv =====
`timescale 1ns / 1ps

module rme_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [rme_pkg::WORD_W-1:0] in_instr_word,
  input  logic signed [rme_pkg::DATA_W-1:0] in_immediate,
  input  logic signed [rme_pkg::DATA_W-1:0] in_keyboard_value,
  output logic                       q_valid,
  input  logic                       q_pop,
  output rme_pkg::instr_t            q_data
);

  import rme_pkg::*;

  logic [OPC_W-1:0] opc;
  logic [IDX_W-1:0] f1;
  logic [IDX_W-1:0] f2;
  instr_t           dec;
  logic             push;

  instr_t     q_r [2];
  logic       wp_r;
  logic       rp_r;
  logic [1:0] cnt_r;

  assign opc = in_instr_word[OPC_W-1:0];
  assign f1  = in_instr_word[R1_LSB +: IDX_W];
  assign f2  = in_instr_word[R2_LSB +: IDX_W];

  always_comb begin
    dec.op   = (opc <= OPC_W'(OP_HALT)) ? op_t'(opc) : OP_NOP;
    dec.cond = (f1 <= IDX_W'(COND_NOT_POS)) ? cond_t'(f1[COND_W-1:0]) : COND_NEVER;
    dec.r1   = f1;
    dec.r2   = f2;
    dec.imm  = unsigned'(in_immediate);
    dec.key  = unsigned'(in_keyboard_value);
  end

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_data   = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (q_pop) begin
        rp_r <= ~rp_r;
      end
      if (push && !q_pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (q_pop && !push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= dec;
    end
  end

endmodule

// ===== src/rme_back.sv =====
`timescale 1ns / 1ps

module rme_back #(
  parameter int NUM_REGS = rme_pkg::NUM_REGS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_valid,
  output logic                       q_pop,
  input  rme_pkg::instr_t            q_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [rme_pkg::DATA_W-1:0] out_next_pc,
  output logic                       out_display_valid,
  output logic signed [rme_pkg::DATA_W-1:0] out_display_value,
  output logic [1:0]                 out_sign_flag,
  output logic                       out_halted
);

  import rme_pkg::*;

  localparam int AW = $clog2(NUM_REGS);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_EXEC = 6'b000010,
    ST_WB   = 6'b000100,
    ST_DIV  = 6'b001000,
    ST_REM  = 6'b010000,
    ST_DONE = 6'b100000
  } state_t;

  state_t              state_r, state_nxt;
  instr_t              ins_r;
  logic [DATA_W-1:0]   pc_r, pc_nxt;
  flag_t               flag_r, flag_nxt;
  logic                halt_r, halt_nxt;
  logic [NUM_REGS-1:0] vld_r;
  logic                out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0]   a_r;
  logic [DATA_W-1:0]   res_r;
  logic                bnz_r;
  logic                disp_en_r;
  logic [DATA_W-1:0]   disp_val_r;
  logic [DATA_W-1:0]   out_pc_r;
  logic                out_disp_en_r;
  logic [DATA_W-1:0]   out_disp_val_r;
  flag_t               out_flag_r;
  logic                out_halt_r;

  logic              we;
  logic [AW-1:0]     waddr;
  logic [DATA_W-1:0] wdata;
  logic [DATA_W-1:0] rd_a;
  logic [DATA_W-1:0] rd_b;
  logic [AW-1:0]     r1a;
  logic [AW-1:0]     r2a;
  logic              r1_ok;
  logic              r2_ok;
  logic [DATA_W-1:0] a;
  logic [DATA_W-1:0] b;
  logic [DATA_W-1:0] alu;
  logic              writes_r1;
  logic              out_load;
  logic              div_start;
  logic              div_done;
  logic [DATA_W-1:0] div_quo;
  logic [DATA_W-1:0] div_rem;
  logic [DATA_W-1:0] div_flag_v;

  rme_ram #(
    .WIDTH(DATA_W),
    .DEPTH(NUM_REGS)
  ) u_ram (
    .clk    (clk),
    .we     (we),
    .waddr  (waddr),
    .wdata  (wdata),
    .re     (q_pop),
    .raddr_a(q_data.r1[AW-1:0]),
    .raddr_b(q_data.r2[AW-1:0]),
    .rdata_a(rd_a),
    .rdata_b(rd_b)
  );

  rme_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .dividend(a),
    .divisor (b),
    .done    (div_done),
    .quo     (div_quo),
    .rem     (div_rem)
  );

  assign r1a   = ins_r.r1[AW-1:0];
  assign r2a   = ins_r.r2[AW-1:0];
  assign r1_ok = ({1'b0, ins_r.r1} < (IDX_W + 1)'(NUM_REGS));
  assign r2_ok = ({1'b0, ins_r.r2} < (IDX_W + 1)'(NUM_REGS));
  assign a     = (r1_ok && vld_r[r1a]) ? rd_a : '0;
  assign b     = (r2_ok && vld_r[r2a]) ? rd_b : '0;

  always_comb begin
    case (ins_r.op) inside
      OP_ADD:          alu = a + b;
      OP_SUB, OP_CMP:  alu = a - b;
      OP_MUL:          alu = a * b;
      OP_COPY:         alu = b;
      OP_LOAD:         alu = ins_r.imm;
      OP_INPUT:        alu = ins_r.key;
      default:         alu = a;
    endcase
  end

  always_comb begin
    case (ins_r.op) inside
      OP_ADD, OP_SUB, OP_MUL, OP_COPY, OP_LOAD, OP_INPUT: writes_r1 = 1'b1;
      default:                                          writes_r1 = 1'b0;
    endcase
  end

  always_comb begin
    if (!bnz_r || !r1_ok) begin
      div_flag_v = a_r;
    end else if (ins_r.r1 == ins_r.r2) begin
      div_flag_v = div_rem;
    end else begin
      div_flag_v = div_quo;
    end
  end

  assign out_load = (state_r == ST_DONE) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    we        = 1'b0;
    waddr     = r1a;
    wdata     = res_r;
    div_start = 1'b0;
    pc_nxt    = pc_r;
    flag_nxt  = flag_r;
    halt_nxt  = halt_r;
    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (halt_r) begin
          state_nxt = ST_DONE;
        end else if (ins_r.op == OP_DIV) begin
          div_start = (b != '0);
          state_nxt = (b != '0) ? ST_DIV : ST_REM;
        end else begin
          state_nxt = ST_WB;
        end
      end
      ST_WB: begin
        we        = writes_r1 && r1_ok;
        pc_nxt    = pc_r + 1'b1;
        state_nxt = ST_DONE;
        case (ins_r.op) inside
          OP_ADD, OP_SUB, OP_MUL: flag_nxt = flag_of(r1_ok ? res_r : '0);
          OP_CMP:                 flag_nxt = flag_of(res_r);
          OP_JMP: begin
            if (cond_met(ins_r.cond, flag_r)) begin
              pc_nxt = pc_r + ins_r.imm;
            end
          end
          OP_HALT: begin
            pc_nxt   = pc_r;
            halt_nxt = 1'b1;
          end
          default: ;
        endcase
      end
      ST_DIV: begin
        if (div_done) begin
          we        = r1_ok;
          wdata     = div_quo;
          state_nxt = ST_REM;
        end
      end
      ST_REM: begin
        we        = bnz_r && r2_ok;
        waddr     = r2a;
        wdata     = div_rem;
        pc_nxt    = pc_r + 1'b1;
        flag_nxt  = flag_of(div_flag_v);
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pc_r        <= '0;
      flag_r      <= FLAG_ZERO;
      halt_r      <= 1'b0;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pc_r        <= pc_nxt;
      flag_r      <= flag_nxt;
      halt_r      <= halt_nxt;
      out_valid_r <= out_valid_nxt;
      if (we) begin
        vld_r[waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      ins_r <= q_data;
    end
    if (state_r == ST_EXEC) begin
      a_r        <= a;
      res_r      <= alu;
      bnz_r      <= (b != '0);
      disp_en_r  <= !halt_r && (ins_r.op == OP_OUT);
      disp_val_r <= (!halt_r && (ins_r.op == OP_OUT)) ? a : '0;
    end
    if (out_load) begin
      out_pc_r       <= pc_r;
      out_disp_en_r  <= disp_en_r;
      out_disp_val_r <= disp_val_r;
      out_flag_r     <= flag_r;
      out_halt_r     <= halt_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_next_pc       = out_pc_r;
  assign out_display_valid = out_disp_en_r;
  assign out_display_value = signed'(out_disp_val_r);
  assign out_sign_flag     = out_flag_r;
  assign out_halted        = out_halt_r;

endmodule
